// ===== src/button_panel_debounce_control_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button panel debounce control
// Shared helpers for the concurrent checks on the top-level ports.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PANEL_DEBOUNCE_CONTROL_TOP_MACROS_SVH
`define BUTTON_PANEL_DEBOUNCE_CONTROL_TOP_MACROS_SVH

// same-cycle implication
`define BPDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bpdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpdc_pkg
// Types, constants and helpers for the button panel debounce control.
// ----------------------------------------------------------------------------
package bpdc_pkg;

    localparam int PIN_W    = 5;
    localparam int BTN_W    = 3;
    localparam int STEP_W   = 4;
    localparam int ATTEN_W  = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [PIN_W-1:0] PIN_MASK = 5'h1f;

    // button codes
    localparam logic [BTN_W-1:0] BTN_FREQ_DN = 3'd0;
    localparam logic [BTN_W-1:0] BTN_FREQ_UP = 3'd1;
    localparam logic [BTN_W-1:0] BTN_ENABLE  = 3'd2;
    localparam logic [BTN_W-1:0] BTN_VOL_DN  = 3'd3;
    localparam logic [BTN_W-1:0] BTN_VOL_UP  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_TOP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_TOP = 2'd1;

    localparam logic [STEP_W-1:0] FREQ_TOP_RST   = 4'd3;
    localparam logic [STEP_W-1:0] VOLUME_TOP_RST = 4'd4;

    localparam logic [STEP_W-1:0]  ATTEN_KNEE = 4'd3;
    localparam logic [ATTEN_W-1:0] ATTEN_MAX  = 3'd4;

    typedef struct packed {
        logic [STEP_W-1:0] freq_top;
        logic [STEP_W-1:0] volume_top;
    } t_cfg;

    typedef struct packed {
        logic               event_valid;
        logic [BTN_W-1:0]   button;
        logic               apply_freq;
        logic               apply_volume;
        logic               apply_power;
        logic [STEP_W-1:0]  freq_step;
        logic [STEP_W-1:0]  volume_step;
        logic               output_enabled;
        logic [ATTEN_W-1:0] attenuation;
    } t_result;

    function automatic logic [ATTEN_W-1:0] atten_of(input logic [STEP_W-1:0] step);
        logic [STEP_W-1:0] diff;
        diff = ATTEN_KNEE - step;
        if (step > ATTEN_KNEE) begin
            return ATTEN_MAX;
        end
        return diff[ATTEN_W-1:0];
    endfunction

endpackage

// ===== src/bpdc_cfg.sv =====
// ----------------------------------------------------------------------------
// bpdc_cfg
// Configuration register file: step index limits.
// ----------------------------------------------------------------------------
module bpdc_cfg
    import bpdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [STEP_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FREQ_TOP:   n_cfg.freq_top   = i_cfg_data;
                CFG_VOLUME_TOP: n_cfg.volume_top = i_cfg_data;
                default:        n_cfg = r_cfg;  // unused index, beat dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freq_top   <= FREQ_TOP_RST;
            r_cfg.volume_top <= VOLUME_TOP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== src/bpdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpdc_ctrl
// Debounce state and step control; computes one result per sampling tick.
// ----------------------------------------------------------------------------
module bpdc_ctrl
    import bpdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [PIN_W-1:0] i_pins,
    input  t_cfg             i_cfg,
    output t_result          o_result
);

    logic [PIN_W-1:0]  r_prev;
    logic              r_armed;
    logic [STEP_W-1:0] r_freq;
    logic [STEP_W-1:0] r_vol;
    logic              r_enable;

    logic [PIN_W-1:0]  n_prev;
    logic              n_armed;
    logic [STEP_W-1:0] n_freq;
    logic [STEP_W-1:0] n_vol;
    logic              n_enable;

    logic [PIN_W-1:0] pressed;
    logic [PIN_W-1:0] held;
    logic [BTN_W-1:0] btn;
    logic             valid;
    logic             ap_f;
    logic             ap_v;
    logic             ap_p;

    assign pressed = ~i_pins & PIN_MASK;
    assign held    = pressed & r_prev;

    // lowest held button wins
    always_comb begin
        btn = BTN_FREQ_DN;
        for (int i = PIN_W - 1; i >= 0; i--) begin
            if (held[i]) begin
                btn = BTN_W'(i);
            end
        end
    end

    always_comb begin
        n_prev   = pressed;
        n_armed  = r_armed;
        n_freq   = r_freq;
        n_vol    = r_vol;
        n_enable = r_enable;
        valid    = 1'b0;
        ap_f     = 1'b0;
        ap_v     = 1'b0;
        ap_p     = 1'b0;
        if (!r_armed) begin
            n_armed = (pressed != r_prev) && (pressed != '0);
        end else begin
            n_armed = 1'b0;
            if (held != '0) begin
                valid = 1'b1;
                case (btn)
                    BTN_FREQ_DN: begin
                        if (r_enable) begin
                            if (r_freq != '0) n_freq = r_freq - 4'd1;
                            ap_f = 1'b1;
                        end
                    end
                    BTN_FREQ_UP: begin
                        if (r_enable) begin
                            if (r_freq < i_cfg.freq_top) n_freq = r_freq + 4'd1;
                            ap_f = 1'b1;
                        end
                    end
                    BTN_ENABLE: begin
                        n_enable = ~r_enable;
                        ap_p     = 1'b1;
                    end
                    BTN_VOL_DN: begin
                        if (r_enable) begin
                            if (r_vol != '0) n_vol = r_vol - 4'd1;
                            ap_v = 1'b1;
                        end
                    end
                    default: begin
                        if (r_enable) begin
                            if (r_vol < i_cfg.volume_top) n_vol = r_vol + 4'd1;
                            ap_v = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_result.event_valid    = valid;
        o_result.button         = valid ? btn : BTN_FREQ_DN;
        o_result.apply_freq     = ap_f;
        o_result.apply_volume   = ap_v;
        o_result.apply_power    = ap_p;
        o_result.freq_step      = n_freq;
        o_result.volume_step    = n_vol;
        o_result.output_enabled = n_enable;
        o_result.attenuation    = atten_of(n_vol);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_armed  <= 1'b0;
            r_freq   <= '0;
            r_vol    <= '0;
            r_enable <= 1'b0;
        end else if (i_fire) begin
            r_prev   <= n_prev;
            r_armed  <= n_armed;
            r_freq   <= n_freq;
            r_vol    <= n_vol;
            r_enable <= n_enable;
        end
    end

endmodule

// ===== src/button_panel_debounce_control_top.sv =====
// ----------------------------------------------------------------------------
// button_panel_debounce_control_top: input beat to result beat through an input register,
// control logic and a result register; 1 beat per cycle while the receiver takes results.
// Reset (synchronous, active low) clears debounce state and step indexes and
// restores the default limits.
// ----------------------------------------------------------------------------
module button_panel_debounce_control_top
    import bpdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIN_W-1:0]      i_pins_raw,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_event_valid,
    output logic [BTN_W-1:0]      o_button,
    output logic                  o_apply_freq,
    output logic                  o_apply_volume,
    output logic                  o_apply_power,
    output logic [STEP_W-1:0]     o_freq_step,
    output logic [STEP_W-1:0]     o_volume_step,
    output logic                  o_output_enabled,
    output logic [ATTEN_W-1:0]    o_attenuation,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [STEP_W-1:0]     i_cfg_data
);

    logic             r_in_valid;
    logic [PIN_W-1:0] r_pins;
    logic             r_out_valid;
    t_result          r_result;

    logic    advance;
    logic    fire;
    logic    in_beat;
    t_cfg    cfg;
    t_result result;

    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;
    assign in_beat    = i_in_valid && o_in_ready;

    bpdc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bpdc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_pins   (r_pins),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_pins <= i_pins_raw;
        end
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_valid    = r_result.event_valid;
    assign o_button         = r_result.button;
    assign o_apply_freq     = r_result.apply_freq;
    assign o_apply_volume   = r_result.apply_volume;
    assign o_apply_power    = r_result.apply_power;
    assign o_freq_step      = r_result.freq_step;
    assign o_volume_step    = r_result.volume_step;
    assign o_output_enabled = r_result.output_enabled;
    assign o_attenuation    = r_result.attenuation;

endmodule

// ===== src/bpdc_checker.sv =====
// ----------------------------------------------------------------------------
// bpdc_checker
// Port-level checks for the button panel debounce control, bound to the top.
// ----------------------------------------------------------------------------
`include "button_panel_debounce_control_top_macros.svh"

module bpdc_checker
    import bpdc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic                 o_event_valid,
    input logic [BTN_W-1:0]     o_button,
    input logic                 o_apply_freq,
    input logic                 o_apply_volume,
    input logic                 o_apply_power,
    input logic [STEP_W-1:0]    o_freq_step,
    input logic [STEP_W-1:0]    o_volume_step,
    input logic                 o_output_enabled,
    input logic [ATTEN_W-1:0]   o_attenuation
);

    // a stalled result beat holds
    `BPDC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_freq_step) && $stable(o_volume_step) && $stable(o_button),
        "stalled result beat changed")

    // strobes only with a confirmed press, and at most one of them
    `BPDC_ASSERT_IMP(a_strobe_evt, i_clk, i_rst_n, o_out_valid && !o_event_valid,
        !o_apply_freq && !o_apply_volume && !o_apply_power && o_button == BTN_FREQ_DN,
        "strobe without event")

    `BPDC_ASSERT_IMP(a_strobe_one, i_clk, i_rst_n, o_out_valid,
        $onehot0({o_apply_freq, o_apply_volume, o_apply_power}), "more than one strobe")

    // step strobes only while enabled
    `BPDC_ASSERT_IMP(a_step_enabled, i_clk, i_rst_n,
        o_out_valid && (o_apply_freq || o_apply_volume), o_output_enabled,
        "step applied while disabled")

    // attenuation tracks the volume step
    `BPDC_ASSERT_IMP(a_atten, i_clk, i_rst_n, o_out_valid,
        o_attenuation == atten_of(o_volume_step), "attenuation mismatch")

endmodule

bind button_panel_debounce_control_top bpdc_checker u_bpdc_checker (.*);

// ===== tb/sv/button_panel_debounce_control_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_panel_debounce_control_top_test
// Drives sampling ticks of the five-button panel through the pin handshake and
// checks every result beat against a cycle-free model of the debounce and the
// step/enable control kept in the bench. Directed cases first, then random
// press sequences under several limit settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module button_panel_debounce_control_top_test;
    import bpdc_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 60;

    // register slots past the two limits, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // pins are active low
    localparam logic [PIN_W-1:0] ALL_RELEASED = PIN_MASK;
    localparam logic [PIN_W-1:0] ALL_PRESSED  = '0;

    logic                 i_clk;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_ready;
    logic [PIN_W-1:0]     i_pins_raw     = ALL_RELEASED;
    logic                 o_out_valid;
    logic                 i_out_ready    = 1'b0;
    logic                 o_event_valid;
    logic [BTN_W-1:0]     o_button;
    logic                 o_apply_freq;
    logic                 o_apply_volume;
    logic                 o_apply_power;
    logic [STEP_W-1:0]    o_freq_step;
    logic [STEP_W-1:0]    o_volume_step;
    logic                 o_output_enabled;
    logic [ATTEN_W-1:0]   o_attenuation;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [STEP_W-1:0]    i_cfg_data     = '0;

    button_panel_debounce_control_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pins_raw       (i_pins_raw),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_event_valid    (o_event_valid),
        .o_button         (o_button),
        .o_apply_freq     (o_apply_freq),
        .o_apply_volume   (o_apply_volume),
        .o_apply_power    (o_apply_power),
        .o_freq_step      (o_freq_step),
        .o_volume_step    (o_volume_step),
        .o_output_enabled (o_output_enabled),
        .o_attenuation    (o_attenuation),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // panel state as the bench sees it
    logic [PIN_W-1:0]  pnl_prev_pressed = '0;
    logic              pnl_armed        = 1'b0;
    logic [STEP_W-1:0] pnl_freq         = '0;
    logic [STEP_W-1:0] pnl_volume       = '0;
    logic              pnl_enabled      = 1'b0;
    logic [STEP_W-1:0] pnl_freq_top     = FREQ_TOP_RST;
    logic [STEP_W-1:0] pnl_volume_top   = VOLUME_TOP_RST;

    t_result pending_ticks[$];

    int  mismatches    = 0;
    int  items_sent    = 0;
    int  cycle_count   = 0;
    int  in_gap_pct    = 0;
    int  out_stall_pct = 0;
    int  hold_req      = 0;
    int  hold_left     = 0;
    bit  in_offering   = 1'b0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d ticks outstanding",
                     cycle_count, pending_ticks.size());
            $display("status: fail");
            $finish;
        end
    end

    // one sampling tick of the panel: debounce, then act on the lowest button held
    function automatic t_result debounce_tick(input logic [PIN_W-1:0] pins);
        logic [PIN_W-1:0] pressed;
        logic [PIN_W-1:0] held;
        t_result          r;
        pressed = ~pins & PIN_MASK;
        r = '0;
        if (!pnl_armed) begin
            pnl_armed = (pressed != pnl_prev_pressed) && (pressed != '0);
        end else begin
            held = pressed & pnl_prev_pressed;
            if (held != '0) begin
                r.event_valid = 1'b1;
                for (int i = PIN_W - 1; i >= 0; i--) begin
                    if (held[i]) r.button = BTN_W'(i);
                end
                case (r.button)
                    BTN_FREQ_DN: begin
                        if (pnl_enabled) begin
                            if (pnl_freq != '0) pnl_freq--;
                            r.apply_freq = 1'b1;
                        end
                    end
                    BTN_FREQ_UP: begin
                        if (pnl_enabled) begin
                            if (pnl_freq < pnl_freq_top) pnl_freq++;
                            r.apply_freq = 1'b1;
                        end
                    end
                    BTN_ENABLE: begin
                        pnl_enabled   = ~pnl_enabled;
                        r.apply_power = 1'b1;
                    end
                    BTN_VOL_DN: begin
                        if (pnl_enabled) begin
                            if (pnl_volume != '0) pnl_volume--;
                            r.apply_volume = 1'b1;
                        end
                    end
                    default: begin
                        if (pnl_enabled) begin
                            if (pnl_volume < pnl_volume_top) pnl_volume++;
                            r.apply_volume = 1'b1;
                        end
                    end
                endcase
            end
            pnl_armed = 1'b0;
        end
        pnl_prev_pressed = pressed;
        r.freq_step      = pnl_freq;
        r.volume_step    = pnl_volume;
        r.output_enabled = pnl_enabled;
        if (pnl_volume > ATTEN_KNEE) r.attenuation = ATTEN_MAX;
        else r.attenuation = ATTEN_W'(ATTEN_KNEE - pnl_volume);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_ticks.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = pending_ticks.pop_front();
                check_field("event_valid", o_event_valid, want.event_valid);
                check_field("button", o_button, want.button);
                check_field("apply_freq", o_apply_freq, want.apply_freq);
                check_field("apply_volume", o_apply_volume, want.apply_volume);
                check_field("apply_power", o_apply_power, want.apply_power);
                check_field("freq_step", o_freq_step, want.freq_step);
                check_field("volume_step", o_volume_step, want.volume_step);
                check_field("output_enabled", o_output_enabled, want.output_enabled);
                check_field("attenuation", o_attenuation, want.attenuation);
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    task automatic in_idle();
        if (in_offering) begin
            i_in_valid  <= 1'b0;
            in_offering = 1'b0;
        end
    endtask

    // offers one tick; valid stays up on return so back-to-back beats have no bubble
    task automatic send_pins(input logic [PIN_W-1:0] raw);
        if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
            in_idle();
            do @(posedge i_clk); while ($urandom_range(99) < in_gap_pct);
        end
        i_pins_raw <= raw;
        if (!in_offering) begin
            i_in_valid  <= 1'b1;
            in_offering = 1'b1;
        end
        do @(posedge i_clk); while (!o_in_ready);
        pending_ticks.push_back(debounce_tick(raw));
        items_sent++;
    endtask

    task automatic wait_drained();
        in_idle();
        do @(posedge i_clk); while (pending_ticks.size() != 0);
    endtask

    // caller drains first; valid is kept up between writes of one burst
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] data,
                             input bit last);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FREQ_TOP:   pnl_freq_top   = data;
            CFG_VOLUME_TOP: pnl_volume_top = data;
            default: ;
        endcase
        if (last) i_cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(input logic [STEP_W-1:0] freq_top,
                              input logic [STEP_W-1:0] volume_top);
        wait_drained();
        cfg_write(CFG_FREQ_TOP, freq_top, 1'b0);
        cfg_write(CFG_VOLUME_TOP, volume_top, 1'b1);
    endtask

    // change, then hold: two beats for one confirmed press
    task automatic press(input logic [BTN_W-1:0] btn);
        logic [PIN_W-1:0] raw;
        raw = PIN_MASK ^ (PIN_W'(1) << btn);
        send_pins(raw);
        send_pins(raw);
    endtask

    task automatic random_sequence();
        int               pick;
        logic [PIN_W-1:0] first;
        logic [PIN_W-1:0] second;
        pick   = $urandom_range(99);
        first  = PIN_W'($urandom_range(1, 31));
        second = ($urandom_range(1) == 1) ? first : PIN_W'($urandom_range(31));
        if (pick < 55) begin
            press(BTN_W'($urandom_range(4)));
            if ($urandom_range(1) == 1) send_pins(ALL_RELEASED);
        end else if (pick < 70) begin
            // chord, confirm acts on whatever overlaps
            send_pins(~first);
            send_pins(~second);
        end else if (pick < 80) begin
            // bounce: gone again on the confirm tick
            send_pins(~first);
            send_pins(ALL_RELEASED);
        end else begin
            send_pins(PIN_W'($urandom_range(31)));
        end
    endtask

    task automatic test_idle_after_reset();
        send_pins(ALL_RELEASED);
        send_pins(ALL_RELEASED);
    endtask

    task automatic test_step_while_disabled();
        press(BTN_FREQ_UP);
        press(BTN_VOL_DN);
        send_pins(ALL_RELEASED);
    endtask

    task automatic test_enable_and_saturate();
        press(BTN_ENABLE);
        // one past the reset frequency top, up to the volume top: strobe still comes at the bound
        repeat (4) begin
            press(BTN_FREQ_UP);
            press(BTN_VOL_UP);
        end
        press(BTN_VOL_DN);
    endtask

    task automatic test_lowest_button_wins();
        send_pins(ALL_PRESSED);
        send_pins(ALL_PRESSED);
    endtask

    task automatic test_release_on_confirm();
        send_pins(PIN_MASK ^ (PIN_W'(1) << BTN_ENABLE));
        send_pins(ALL_RELEASED);
    endtask

    task automatic test_index_above_top();
        set_limits(4'd1, VOLUME_TOP_RST);
        press(BTN_FREQ_UP);
        press(BTN_FREQ_DN);
    endtask

    task automatic test_spare_register_writes();
        wait_drained();
        cfg_write(CFG_SPARE_LO, 4'hf, 1'b0);
        cfg_write(CFG_SPARE_HI, 4'ha, 1'b1);
        press(BTN_FREQ_UP);
        press(BTN_FREQ_UP);
    endtask

    task automatic test_full_range();
        set_limits(4'hf, 4'hf);
        repeat (16) begin
            press(BTN_FREQ_UP);
            press(BTN_VOL_UP);
        end
        repeat (16) begin
            press(BTN_FREQ_DN);
            press(BTN_VOL_DN);
        end
        set_limits(4'h0, 4'h0);
        press(BTN_FREQ_UP);
        press(BTN_VOL_UP);
    endtask

    task automatic test_backpressure();
        int start;
        start         = items_sent;
        in_gap_pct    = 0;
        out_stall_pct = 0;
        set_limits(4'd9, 4'd6);
        hold_req = HOLD_CYCLES;
        while (items_sent - start < 40) random_sequence();
    endtask

    task automatic test_random_traffic(input int n_items, input int gap_pct,
                                       input int stall_pct,
                                       input logic [STEP_W-1:0] freq_top,
                                       input logic [STEP_W-1:0] volume_top);
        int start;
        set_limits(freq_top, volume_top);
        in_gap_pct    = gap_pct;
        out_stall_pct = stall_pct;
        start         = items_sent;
        while (items_sent - start < n_items) random_sequence();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_after_reset();
        test_step_while_disabled();
        test_enable_and_saturate();
        test_lowest_button_wins();
        test_release_on_confirm();
        test_index_above_top();
        test_spare_register_writes();
        test_full_range();
        test_backpressure();

        test_random_traffic(240, 0, 0, 4'hf, 4'hf);
        test_random_traffic(200, 72, 0, 4'h0, 4'd9);
        test_random_traffic(200, 0, 72, STEP_W'($urandom_range(15)),
                            STEP_W'($urandom_range(15)));
        test_random_traffic(200, 19, 19, 4'd5, 4'h0);
        test_random_traffic(200, 0, 0, STEP_W'($urandom_range(15)),
                            STEP_W'($urandom_range(15)));

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
